### src/ini_setting_scanner_unit_assert.svh
// Assertion macros for the setting scanner checker.
`ifndef INI_SETTING_SCANNER_UNIT_ASSERT_SVH
`define INI_SETTING_SCANNER_UNIT_ASSERT_SVH

// Check that cond holds at every clock edge outside reset.
`define ISS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ISS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/iss_pkg.sv
`timescale 1ns / 1ps

package iss_pkg;

   localparam int MAX_BODY_BYTES = 65536;
   // offset counter holds MAX_BODY_BYTES itself
   localparam int OFS_W = $clog2(MAX_BODY_BYTES) + 1;
   localparam int NAME_W = 16;
   localparam int VAL_W = 17;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW = QUEUE_AW + 1;

   typedef enum logic {
      KIND_SETTING = 1'b0,
      KIND_END     = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [NAME_W-1:0] name_offset;
      logic [NAME_W-1:0] name_length;
      logic [VAL_W-1:0]  value_offset;
      logic [VAL_W-1:0]  value_length;
      logic              overflow;
      logic              last_result;
   } rsp_type;

   // up to two result words per accepted item; word 1 only with word 0
   typedef struct packed {
      logic    valid0;
      logic    valid1;
      rsp_type data0;
      rsp_type data1;
   } push_type;

endpackage

### src/iss_parser.sv
`timescale 1ns / 1ps

module iss_parser
   import iss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] text_byte,
   input  logic       end_of_body,
   output push_type   push
);

   typedef enum logic [2:0] {
      MODE_SKIP    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_NAME    = 3'd2,
      MODE_VALUE   = 3'd3,
      MODE_DONE    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      QUOTE_NONE   = 2'd0,
      QUOTE_SINGLE = 2'd1,
      QUOTE_DOUBLE = 2'd2
   } quote_type;

   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_BRACKET   = 8'h5B;
   localparam logic [7:0] CH_EQUALS    = 8'h3D;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(MAX_BODY_BYTES);

   mode_type          mode_ff, mode_in;
   logic [OFS_W-1:0]  offset_ff, offset_in;
   logic [OFS_W-1:0]  name_start_ff, name_start_in;
   logic [OFS_W-1:0]  trim_end_ff, trim_end_in;
   logic [OFS_W-1:0]  value_start_ff, value_start_in;
   quote_type         quote_ff, quote_in;
   logic              bslash_ff, bslash_in;
   logic              ovf_ff, ovf_in;

   logic              white;
   logic              at_max;
   logic [OFS_W-1:0]  idx_inc;
   logic [OFS_W-1:0]  vstart_sat;
   logic              has_name;
   logic [OFS_W-1:0]  vlen;
   logic [OFS_W-1:0]  nlen;
   rsp_type           setting;
   rsp_type           end_mark;

   assign white = (text_byte == CH_SPACE) || ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
   // the byte index is the offset itself; it saturates at the limit
   assign at_max = (offset_ff == OFS_MAX);
   assign idx_inc = offset_ff + OFS_W'(1);
   assign vstart_sat = at_max ? OFS_MAX : idx_inc;
   assign has_name = (trim_end_ff > name_start_ff);
   // a value ends at the current byte or at the body end: both are offset_ff
   assign vlen = (offset_ff >= value_start_ff) ? (offset_ff - value_start_ff) : '0;
   assign nlen = trim_end_ff - name_start_ff;

   always_comb begin
      setting.kind         = KIND_SETTING;
      setting.name_offset  = name_start_ff[NAME_W-1:0];
      setting.name_length  = nlen[NAME_W-1:0];
      setting.value_offset = VAL_W'(value_start_ff);
      setting.value_length = VAL_W'(vlen);
      setting.overflow     = end_of_body ? ovf_ff : (ovf_ff | at_max);
      setting.last_result  = !end_of_body;

      end_mark = '0;
      end_mark.kind        = KIND_END;
      end_mark.overflow    = ovf_ff;
      end_mark.last_result = 1'b1;
   end

   always_comb begin
      mode_in        = mode_ff;
      offset_in      = offset_ff;
      name_start_in  = name_start_ff;
      trim_end_in    = trim_end_ff;
      value_start_in = value_start_ff;
      quote_in       = quote_ff;
      bslash_in      = bslash_ff;
      ovf_in         = ovf_ff;
      push           = '0;

      if (accept && end_of_body) begin
         if ((mode_ff == MODE_VALUE) && has_name) begin
            push.valid0 = 1'b1;
            push.data0  = setting;
            push.valid1 = 1'b1;
            push.data1  = end_mark;
         end else begin
            push.valid0 = 1'b1;
            push.data0  = end_mark;
         end
         mode_in        = MODE_SKIP;
         offset_in      = '0;
         name_start_in  = '0;
         trim_end_in    = '0;
         value_start_in = '0;
         quote_in       = QUOTE_NONE;
         bslash_in      = 1'b0;
         ovf_in         = 1'b0;
      end else if (accept) begin
         offset_in = at_max ? offset_ff : idx_inc;
         ovf_in    = ovf_ff | at_max;
         unique case (mode_ff)
            MODE_SKIP: begin
               if (white) begin
                  mode_in = MODE_SKIP;
               end else if (text_byte == CH_BRACKET) begin
                  mode_in = MODE_DONE;
               end else if (text_byte == CH_HASH) begin
                  mode_in = MODE_COMMENT;
               end else if (text_byte == CH_EQUALS) begin
                  // empty name; the setting is dropped at its end
                  name_start_in  = offset_ff;
                  trim_end_in    = offset_ff;
                  value_start_in = vstart_sat;
                  quote_in       = QUOTE_NONE;
                  bslash_in      = 1'b0;
                  mode_in        = MODE_VALUE;
               end else begin
                  name_start_in = offset_ff;
                  trim_end_in   = idx_inc;
                  mode_in       = MODE_NAME;
               end
            end
            MODE_NAME: begin
               if (text_byte == CH_EQUALS) begin
                  value_start_in = vstart_sat;
                  quote_in       = QUOTE_NONE;
                  bslash_in      = 1'b0;
                  mode_in        = MODE_VALUE;
               end else if (text_byte == CH_NEWLINE) begin
                  mode_in = MODE_SKIP;
               end else if (!white) begin
                  trim_end_in = idx_inc;
               end
            end
            MODE_COMMENT: begin
               if (text_byte == CH_NEWLINE) begin
                  mode_in = MODE_SKIP;
               end
            end
            MODE_VALUE: begin
               if (bslash_ff && (text_byte == CH_NEWLINE)) begin
                  // line continuation
                  bslash_in = 1'b0;
               end else begin
                  bslash_in = (text_byte == CH_BACKSLASH);
                  if (quote_ff != QUOTE_NONE) begin
                     if (((quote_ff == QUOTE_SINGLE) && (text_byte == CH_SQUOTE)) ||
                         ((quote_ff == QUOTE_DOUBLE) && (text_byte == CH_DQUOTE))) begin
                        quote_in = QUOTE_NONE;
                     end
                  end else if (text_byte == CH_SQUOTE) begin
                     quote_in = QUOTE_SINGLE;
                  end else if (text_byte == CH_DQUOTE) begin
                     quote_in = QUOTE_DOUBLE;
                  end else if (text_byte == CH_NEWLINE) begin
                     push.valid0 = has_name;
                     push.data0  = setting;
                     mode_in     = MODE_SKIP;
                  end
               end
            end
            default: begin
               mode_in = MODE_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_SKIP;
         offset_ff      <= '0;
         name_start_ff  <= '0;
         trim_end_ff    <= '0;
         value_start_ff <= '0;
         quote_ff       <= QUOTE_NONE;
         bslash_ff      <= 1'b0;
         ovf_ff         <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         offset_ff      <= offset_in;
         name_start_ff  <= name_start_in;
         trim_end_ff    <= trim_end_in;
         value_start_ff <= value_start_in;
         quote_ff       <= quote_in;
         bslash_ff      <= bslash_in;
         ovf_ff         <= ovf_in;
      end
   end

endmodule

### src/iss_out_queue.sv
`timescale 1ns / 1ps

module iss_out_queue
   import iss_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_word
);

   rsp_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic [QUEUE_AW-1:0] wr_ptr_next;
   logic [QUEUE_CW-1:0] n_push;
   logic                pop;

   // two free entries cover the worst case of one item
   assign room = (count_ff <= QUEUE_CW'(QUEUE_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_word = mem_ff[rd_ptr_ff];
   assign pop = rsp_valid && rsp_ready;
   assign wr_ptr_next = wr_ptr_ff + QUEUE_AW'(1);
   assign n_push = QUEUE_CW'(push.valid0) + QUEUE_CW'(push.valid1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + n_push[QUEUE_AW-1:0];
      rd_ptr_in = pop ? (rd_ptr_ff + QUEUE_AW'(1)) : rd_ptr_ff;
      count_in  = count_ff + n_push - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         mem_ff[wr_ptr_ff] <= push.data0;
      end
      if (push.valid1) begin
         mem_ff[wr_ptr_next] <= push.data1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### src/ini_setting_scanner_unit.sv
`timescale 1ns / 1ps

// Setting scanner for one INI section body. Feed the body one byte per word on
// req_, then a word with req_end_of_body set; each name=value line with a
// non-empty name comes back on rsp_ as offsets and lengths, and the terminator
// adds an end-of-section word. One word is taken per clock cycle while req_ready
// is high: the parser state updates in the cycle a word is accepted and its
// results land in a four-entry output queue, whose head drives rsp_. req_ready
// drops only while fewer than two queue entries are free, i.e. when the
// consumer stalls.
module ini_setting_scanner_unit
   import iss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_text_byte,
   input  logic              req_end_of_body,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [NAME_W-1:0] rsp_name_offset,
   output logic [NAME_W-1:0] rsp_name_length,
   output logic [VAL_W-1:0]  rsp_value_offset,
   output logic [VAL_W-1:0]  rsp_value_length,
   output logic              rsp_overflow,
   output logic              rsp_last_result
);

   logic     accept;
   logic     room;
   push_type push;
   rsp_type  rsp_word;

   assign req_ready = room;
   assign accept = req_valid && room;

   iss_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_body (req_end_of_body),
      .push        (push)
   );

   iss_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_kind         = rsp_word.kind;
   assign rsp_name_offset  = rsp_word.name_offset;
   assign rsp_name_length  = rsp_word.name_length;
   assign rsp_value_offset = rsp_word.value_offset;
   assign rsp_value_length = rsp_word.value_length;
   assign rsp_overflow     = rsp_word.overflow;
   assign rsp_last_result  = rsp_word.last_result;

endmodule

### src/iss_checker.sv
`timescale 1ns / 1ps

`include "ini_setting_scanner_unit_assert.svh"

module iss_checker
   import iss_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [7:0]        req_text_byte,
   input logic              req_end_of_body,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_kind,
   input logic [NAME_W-1:0] rsp_name_offset,
   input logic [NAME_W-1:0] rsp_name_length,
   input logic [VAL_W-1:0]  rsp_value_offset,
   input logic [VAL_W-1:0]  rsp_value_length,
   input logic              rsp_overflow,
   input logic              rsp_last_result
);

   logic stall;
   logic rsp_take;

   assign stall = rsp_valid && !rsp_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   `ISS_ASSERT_NEXT(a_rsp_hold, clock, reset, stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_name_offset) && $stable(rsp_value_length) && $stable(rsp_last_result), "rsp word changed while stalled")

   `ISS_ASSERT_ALWAYS(a_end_clean, clock, reset, !(rsp_valid && rsp_kind) || (rsp_last_result && (rsp_name_offset == '0) && (rsp_name_length == '0) && (rsp_value_offset == '0) && (rsp_value_length == '0)), "end marker carries setting fields")

   `ISS_ASSERT_ALWAYS(a_value_after_eq, clock, reset, !(rsp_valid && !rsp_kind) || (rsp_value_offset != '0), "setting value offset cannot be zero")

   // a setting that is not last belongs to a terminator, whose end marker follows
   `ISS_ASSERT_NEXT(a_end_follows, clock, reset, rsp_take && !rsp_last_result, rsp_valid && rsp_kind, "end marker missing after flushed setting")

endmodule

bind ini_setting_scanner_unit iss_checker u_iss_checker (.*);

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import iss_pkg::*;

   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NL        = 8'h0A;
   localparam logic [7:0] CH_VTAB      = 8'h0B;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_EQUALS    = 8'h3D;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_X   = 8'h78;

   localparam int BURST_MAX     = 14;
   localparam int TAIL_WORDS    = 200;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_REPORTS   = 100;
   localparam int RANDOM_WORDS  = 1500;

   typedef enum logic [2:0] {
      SCAN_SKIP, SCAN_COMMENT, SCAN_NAME, SCAN_VALUE, SCAN_DONE
   } scan_mode_type;

   typedef enum logic [1:0] {QUOTE_NONE, QUOTE_SINGLE, QUOTE_DOUBLE} quote_type;

   typedef struct {
      logic [7:0] text_byte;
      logic       end_of_body;
      bit         drain_first;
   } text_word_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_text_byte = '0;
   logic              req_end_of_body = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_kind;
   logic [NAME_W-1:0] rsp_name_offset;
   logic [NAME_W-1:0] rsp_name_length;
   logic [VAL_W-1:0]  rsp_value_offset;
   logic [VAL_W-1:0]  rsp_value_length;
   logic              rsp_overflow;
   logic              rsp_last_result;

   // scanner state as seen from the stream
   scan_mode_type scan_mode;
   int unsigned   scan_pos;
   int unsigned   key_start;
   int unsigned   key_end;
   int unsigned   val_start;
   quote_type     quote_open;
   bit            escape_seen;
   bit            body_overflow;

   rsp_type       expected_reports[$];
   text_word_type text_words[$];

   bit          req_taken;
   int unsigned words_taken;
   int unsigned mismatches;
   int unsigned cycle_count;
   int unsigned cycle_limit = 32'hFFFF_FFFF;
   int          send_gap;
   int          recv_gap;
   int          stretch_left;
   bit          quiet;
   bit          calm;

   ini_setting_scanner_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_end_of_body (req_end_of_body),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_name_offset (rsp_name_offset),
      .rsp_name_length (rsp_name_length),
      .rsp_value_offset(rsp_value_offset),
      .rsp_value_length(rsp_value_length),
      .rsp_overflow    (rsp_overflow),
      .rsp_last_result (rsp_last_result)
   );

   function automatic bit is_blank_byte(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic void clear_scanner();
      scan_mode = SCAN_SKIP;
      scan_pos = 0;
      key_start = 0;
      key_end = 0;
      val_start = 0;
      quote_open = QUOTE_NONE;
      escape_seen = 1'b0;
      body_overflow = 1'b0;
   endfunction

   function automatic rsp_type make_report(kind_type kind, int unsigned noff,
                                           int unsigned nlen, int unsigned voff,
                                           int unsigned vlen, bit last);
      rsp_type r;
      r.kind = kind;
      r.name_offset = noff[NAME_W-1:0];
      r.name_length = nlen[NAME_W-1:0];
      r.value_offset = voff[VAL_W-1:0];
      r.value_length = vlen[VAL_W-1:0];
      r.overflow = body_overflow;
      r.last_result = last;
      return r;
   endfunction

   // drop settings whose trimmed name is empty
   function automatic void report_setting(int unsigned end_pos, bit last);
      int unsigned vlen;
      if (key_end > key_start) begin
         vlen = (end_pos >= val_start) ? end_pos - val_start : 0;
         expected_reports.push_back(make_report(KIND_SETTING, key_start,
                                                key_end - key_start, val_start,
                                                vlen, last));
      end
   endfunction

   function automatic void scan_word(logic [7:0] c, logic eob);
      int unsigned idx;
      if (eob) begin
         if (scan_mode == SCAN_VALUE)
            report_setting(scan_pos, 1'b0);
         expected_reports.push_back(make_report(KIND_END, 0, 0, 0, 0, 1'b1));
         clear_scanner();
      end else begin
         // saturate the offset once the body runs past its limit
         if (scan_pos >= MAX_BODY_BYTES) begin
            body_overflow = 1'b1;
            scan_pos = MAX_BODY_BYTES;
            idx = MAX_BODY_BYTES;
         end else begin
            idx = scan_pos;
            scan_pos++;
         end
         case (scan_mode)
            SCAN_SKIP: begin
               if (!is_blank_byte(c)) begin
                  if (c == CH_LBRACKET)
                     scan_mode = SCAN_DONE;
                  else if (c == CH_HASH)
                     scan_mode = SCAN_COMMENT;
                  else begin
                     key_start = idx;
                     key_end = idx;
                     scan_mode = SCAN_NAME;
                  end
               end
            end
            SCAN_COMMENT: begin
               if (c == CH_NL)
                  scan_mode = SCAN_SKIP;
            end
            SCAN_VALUE: begin
               if (escape_seen && c == CH_NL)
                  escape_seen = 1'b0;
               else begin
                  escape_seen = (c == CH_BACKSLASH);
                  if (quote_open != QUOTE_NONE) begin
                     if ((quote_open == QUOTE_SINGLE && c == CH_SQUOTE) ||
                         (quote_open == QUOTE_DOUBLE && c == CH_DQUOTE))
                        quote_open = QUOTE_NONE;
                  end else if (c == CH_SQUOTE)
                     quote_open = QUOTE_SINGLE;
                  else if (c == CH_DQUOTE)
                     quote_open = QUOTE_DOUBLE;
                  else if (c == CH_NL) begin
                     report_setting(idx, 1'b1);
                     scan_mode = SCAN_SKIP;
                  end
               end
            end
            default: ;
         endcase
         // the byte that opens a name line is handled as part of it
         if (scan_mode == SCAN_NAME) begin
            if (c == CH_EQUALS) begin
               val_start = (idx + 1 > MAX_BODY_BYTES) ? MAX_BODY_BYTES : idx + 1;
               quote_open = QUOTE_NONE;
               escape_seen = 1'b0;
               scan_mode = SCAN_VALUE;
            end else if (c == CH_NL)
               scan_mode = SCAN_SKIP;
            else if (!is_blank_byte(c))
               key_end = idx + 1;
         end
      end
   endfunction

   function automatic void compare_field(string field, logic [31:0] want,
                                         logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   function automatic void add_byte(logic [7:0] c);
      text_word_type w;
      w.text_byte = c;
      w.end_of_body = 1'b0;
      w.drain_first = 1'b0;
      text_words.push_back(w);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endfunction

   function automatic void add_end(logic [7:0] filler, bit drain);
      text_word_type w;
      w.text_byte = filler;
      w.end_of_body = 1'b1;
      w.drain_first = drain;
      text_words.push_back(w);
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 5))
         0: return CH_TAB;
         1: return CH_NL;
         2: return CH_VTAB;
         3: return CH_FF;
         4: return CH_CR;
         default: return CH_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] pick_name_byte();
      case ($urandom_range(0, 9))
         0: return 8'($urandom_range(0, 255));
         1: return CH_SPACE;
         default: return CH_LOWER_A + 8'($urandom_range(0, 25));
      endcase
   endfunction

   function automatic logic [7:0] pick_value_byte();
      case ($urandom_range(0, 23))
         0: return CH_SQUOTE;
         1: return CH_DQUOTE;
         2: return CH_BACKSLASH;
         3: return CH_EQUALS;
         4, 5: return CH_SPACE;
         6, 7: return 8'($urandom_range(0, 255));
         8: return CH_HASH;
         default: return CH_LOWER_A + 8'($urandom_range(0, 25));
      endcase
   endfunction

   function automatic void add_name_run();
      add_byte(CH_LOWER_A + 8'($urandom_range(0, 25)));
      repeat ($urandom_range(0, 5))
         add_byte(pick_name_byte());
   endfunction

   function automatic void add_setting_line();
      logic [7:0] q;
      repeat ($urandom_range(0, 2))
         add_byte(pick_blank());
      if ($urandom_range(0, 9) != 0)
         add_name_run();
      repeat ($urandom_range(0, 2))
         add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      add_byte(CH_EQUALS);
      repeat ($urandom_range(0, 8)) begin
         case ($urandom_range(0, 9))
            0: begin
               q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
               add_byte(q);
               repeat ($urandom_range(0, 4))
                  add_byte($urandom_range(0, 2) == 0 ? CH_NL : pick_value_byte());
               // leave a few quotes open so the value spills over lines
               if ($urandom_range(0, 7) != 0)
                  add_byte(q);
            end
            1: begin
               add_byte(CH_BACKSLASH);
               add_byte(CH_NL);
            end
            default: add_byte(pick_value_byte());
         endcase
      end
      add_byte(CH_NL);
   endfunction

   function automatic void add_body(int min_len, bit allow_section, bit drain);
      int base;
      bit closed;
      base = text_words.size();
      closed = 1'b0;
      while (!closed && text_words.size() - base < min_len) begin
         case ($urandom_range(0, 19))
            0, 1: begin
               add_byte(CH_HASH);
               repeat ($urandom_range(0, 8))
                  add_byte(pick_value_byte());
               add_byte(CH_NL);
            end
            2: repeat ($urandom_range(1, 3)) add_byte(pick_blank());
            3: begin
               add_name_run();
               add_byte(CH_NL);
            end
            4: repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            5: begin
               if (allow_section && $urandom_range(0, 3) == 0) begin
                  add_byte(CH_LBRACKET);
                  repeat ($urandom_range(0, 3))
                     add_byte(8'($urandom_range(0, 255)));
                  closed = 1'b1;
               end
            end
            default: add_setting_line();
         endcase
      end
      if (!closed) begin
         case ($urandom_range(0, 3))
            0: begin
               add_name_run();
               add_byte(CH_EQUALS);
               repeat ($urandom_range(0, 3))
                  add_byte(pick_value_byte());
            end
            1: add_name_run();
            default: ;
         endcase
      end
      add_end(8'($urandom_range(0, 255)), drain);
   endfunction

   // one quoted value spanning almost the whole body, then settings placed
   // on both sides of the offset limit
   function automatic void add_oversized_body();
      int base;
      logic [7:0] c;
      base = text_words.size();
      add_text("k='");
      while (text_words.size() - base < MAX_BODY_BYTES - 40) begin
         c = 8'($urandom_range(0, 255));
         add_byte(c == CH_SQUOTE ? CH_LOWER_X : c);
      end
      add_text("'\n#");
      while (text_words.size() - base < MAX_BODY_BYTES - 2)
         add_byte(CH_LOWER_X);
      add_byte(CH_NL);
      add_text("a=v\n");
      repeat ($urandom_range(2, 20))
         add_setting_line();
      add_end(8'($urandom_range(0, 255)), 1'b0);
   endfunction

   initial begin : clock_gen
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : reset_gen
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("FAIL ini_setting_scanner_unit");
         $finish;
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      req_taken = !reset && req_valid && req_ready;
      if (req_taken) begin
         scan_word(req_text_byte, req_end_of_body);
         words_taken++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected word, actual kind %0d name %0d+%0d value %0d+%0d",
                        $time, rsp_kind, rsp_name_offset, rsp_name_length,
                        rsp_value_offset, rsp_value_length);
         end else begin
            want = expected_reports.pop_front();
            compare_field("kind", 32'(want.kind), 32'(rsp_kind));
            compare_field("name_offset", 32'(want.name_offset), 32'(rsp_name_offset));
            compare_field("name_length", 32'(want.name_length), 32'(rsp_name_length));
            compare_field("value_offset", 32'(want.value_offset), 32'(rsp_value_offset));
            compare_field("value_length", 32'(want.value_length), 32'(rsp_value_length));
            compare_field("overflow", 32'(want.overflow), 32'(rsp_overflow));
            compare_field("last_result", 32'(want.last_result), 32'(rsp_last_result));
         end
      end
   end

   always @(negedge clock) begin : driver
      bit            send;
      text_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         // alternate stretches with and without idling
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(20, 300);
            quiet = ($urandom_range(0, 3) == 0);
         end else
            stretch_left--;
         calm = quiet || text_words.size() < TAIL_WORDS;

         // hold the current word until it is taken
         send = req_valid && !req_taken;
         if (!send) begin
            if (send_gap > 0)
               send_gap--;
            else if (text_words.size() > 0 &&
                     !(text_words[0].drain_first && expected_reports.size() > 0)) begin
               if (!calm && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, BURST_MAX) - 1;
               else begin
                  w = text_words.pop_front();
                  req_text_byte <= w.text_byte;
                  req_end_of_body <= w.end_of_body;
                  send = 1'b1;
               end
            end
         end
         req_valid <= send;

         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(1, BURST_MAX) - 1;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= 1'b1;
      end
   end

   initial begin : stimulus
      int base;
      int oversized_len;
      bit oversized_done;
      int unsigned total;
      clear_scanner();

      // empty body, terminator byte ignored
      add_end(8'hFF, 1'b0);
      // quoted newline, '=' inside the value, backslash as the last byte
      add_text("k='\n'=\\");
      add_end(8'h00, 1'b0);
      // empty name, comment, line without '=', section end and ignored tail
      add_text("=\n#\nx\n[");
      add_byte(8'h00);
      add_end(8'h5A, 1'b1);
      // continuation, trimmed name, high byte name, unclosed quote to body end
      add_text("b =\\\n\n");
      add_byte(8'hFF);
      add_text("=\"\n");
      add_end(8'hA5, 1'b0);
      // line without '=' at body end
      add_text(" z");
      add_end(8'h3C, 1'b0);

      base = text_words.size();
      oversized_len = 0;
      oversized_done = 1'b0;
      while (text_words.size() - base - oversized_len < RANDOM_WORDS) begin
         if (!oversized_done && text_words.size() - base > RANDOM_WORDS / 2) begin
            oversized_len = text_words.size();
            add_oversized_body();
            oversized_len = text_words.size() - oversized_len;
            oversized_done = 1'b1;
         end
         add_body($urandom_range(4, 120), 1'b1, $urandom_range(0, 15) == 0);
      end

      total = text_words.size();
      cycle_limit = 200 * total + 20000;

      wait (!reset);
      while (words_taken < total || expected_reports.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_reports.size() == 0)
         $display("PASS ini_setting_scanner_unit");
      else
         $display("FAIL ini_setting_scanner_unit");
      $finish;
   end

endmodule

### ini_setting_scanner_unit.f
+incdir+src
src/iss_pkg.sv
src/iss_parser.sv
src/iss_out_queue.sv
src/ini_setting_scanner_unit.sv
src/iss_checker.sv
test/testbench.sv
